@@ rtl/dnsd_pkg.sv @@
// ----------------------------------------------------------------------------
// DNS name decompressor package
// Shared constants, payload structs and sequencer states for the name
// decompressor.
// ----------------------------------------------------------------------------
package dnsd_pkg;

	// Default sizes for the top-level parameters.
	localparam int PACKET_BYTES_DEF   = 512;
	localparam int MAX_NAME_BYTES_DEF = 255;
	localparam int CHUNK_BYTES_DEF    = 8;

	// Field widths of the external words.
	localparam int HOPS_W     = 7;
	localparam int POSITION_W = 9;
	localparam int CHARS_W    = 64;
	localparam int COUNT_W    = 4;
	localparam int CONSUMED_W = 9;
	localparam int FAULT_W    = 2;

	// A header byte at or above this value opens a two-byte compression pointer.
	localparam logic [7:0] PTR_MIN = 8'd192;
	// A pointer carries a 14-bit target offset.
	localparam int PTR_OFFSET_W = 14;
	localparam logic [7:0] DOT_CHAR = 8'h2E;
	localparam logic [HOPS_W-1:0] HOPS_RESET = 7'd16;

	// Item kinds.
	localparam logic KIND_LOAD   = 1'b0;
	localparam logic KIND_DECODE = 1'b1;

	// Fault codes.
	localparam logic [FAULT_W-1:0] FAULT_NONE = 2'd0;
	localparam logic [FAULT_W-1:0] FAULT_HOPS = 2'd1;
	localparam logic [FAULT_W-1:0] FAULT_LONG = 2'd2;

	typedef struct packed {
		logic                  kind;
		logic [7:0]            byte_value;
		logic [POSITION_W-1:0] position;
	} dnsd_in_t;

	typedef struct packed {
		logic [CHARS_W-1:0]    name_chars;
		logic [COUNT_W-1:0]    char_count;
		logic                  last;
		logic [CONSUMED_W-1:0] consumed_length;
		logic [FAULT_W-1:0]    fault;
	} dnsd_out_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_WRAP,
		S_HDR,
		S_PTR_LO,
		S_CH,
		S_GATHER,
		S_FINAL
	} dnsd_state_t;

endpackage

@@ rtl/dnsd_ram.sv @@
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module dnsd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 512,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port and registered read port.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data <= mem_q[rd_addr];
	end

endmodule

@@ rtl/dns_name_decompressor.sv @@
// ----------------------------------------------------------------------------
// DNS name decompressor
// Stores packet bytes and expands compressed domain names into dotted text.
// ----------------------------------------------------------------------------
// A load word writes one packet byte at its position, which is first reduced
// by repeated subtraction of PACKET_BYTES when PACKET_BYTES is not a power of
// two. A decode word walks the name, reading the packet buffer once per label
// header, per label character and per compression pointer byte (the target
// offset of a pointer is reduced the same way). The name is collected in a
// name buffer and then replayed at one character per cycle into words of up to
// CHUNK_BYTES characters, the replay stalling while the output register still
// holds a word that has not been taken. Each buffer has a single read port.
// The block takes no new word until the last result word of a decode has
// been handed to the output register; faults produce one result word only.
// ----------------------------------------------------------------------------
module dns_name_decompressor
	import dnsd_pkg::*;
#(
	parameter int PACKET_BYTES   = PACKET_BYTES_DEF,
	parameter int MAX_NAME_BYTES = MAX_NAME_BYTES_DEF,
	parameter int CHUNK_BYTES    = CHUNK_BYTES_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_valid,
	output logic              item_ready,
	input  dnsd_in_t          item,
	output logic              result_valid,
	input  logic              result_ready,
	output dnsd_out_t         result,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [HOPS_W-1:0] cfg_data
);

	localparam int ADDR_W = $clog2(PACKET_BYTES);
	localparam int NW     = $clog2(MAX_NAME_BYTES);
	localparam int LW     = $clog2(MAX_NAME_BYTES + 1);
	localparam int CW     = ($clog2(MAX_NAME_BYTES + 4) > 9) ? $clog2(MAX_NAME_BYTES + 4) : 9;
	localparam int CPW    = $clog2(CHUNK_BYTES + 1);
	localparam int RED_W  = PTR_OFFSET_W;
	localparam bit PKT_POW2 = (PACKET_BYTES & (PACKET_BYTES - 1)) == 0;
	localparam logic [RED_W:0]  PKT_LIM  = (RED_W + 1)'(PACKET_BYTES);
	localparam logic [ADDR_W-1:0] PKT_TOP = ADDR_W'(PACKET_BYTES - 1);
	localparam logic [LW-1:0]   NAME_MAX = LW'(MAX_NAME_BYTES);
	localparam logic [CPW-1:0]  CHUNK_N  = CPW'(CHUNK_BYTES);

	dnsd_state_t state_q, state_d;
	logic                kind_q, kind_d;
	logic [7:0]          bval_q, bval_d;
	logic [RED_W-1:0]    red_q, red_d;
	logic [ADDR_W-1:0]   p_q, p_d;
	logic [7:0]          cnt_q, cnt_d;
	logic [HOPS_W:0]     hops_q, hops_d;
	logic [LW-1:0]       len_q, len_d;
	logic [CW-1:0]       cons_q, cons_d;
	logic                comp_q, comp_d;
	logic                labels_q, labels_d;
	logic [5:0]          hi_q, hi_d;
	logic [FAULT_W-1:0]  fault_q, fault_d;
	logic [LW-1:0]       rp_q, rp_d;
	logic [CPW-1:0]      cpos_q, cpos_d;
	logic [CHARS_W-1:0]  chunk_q, chunk_d;
	dnsd_out_t           out_q, out_d;
	logic                out_valid_q, out_valid_d;
	logic [HOPS_W-1:0]   max_hops_q;

	logic                pk_we;
	logic [7:0]          pk_rd;
	logic                n_we;
	logic [7:0]          n_wdata;
	logic [7:0]          n_rd;

	logic                out_free;
	logic                wrap_done;
	logic [ADDR_W-1:0]   p_inc;
	logic [HOPS_W:0]     hops_inc;
	logic [LW-1:0]       rp_inc;
	logic [CPW-1:0]      cpos_inc;
	logic [CHARS_W-1:0]  chunk_new;
	logic                is_last;
	logic                chunk_full;

	// Packet buffer: the read address follows the next walk pointer, so the
	// read data always holds the byte at the current walk pointer.
	dnsd_ram #(
		.WIDTH (8),
		.DEPTH (PACKET_BYTES)
	) u_pkt_ram (
		.clk     (clk),
		.wr_en   (pk_we),
		.wr_addr (red_q[ADDR_W-1:0]),
		.wr_data (bval_q),
		.rd_addr (p_d),
		.rd_data (pk_rd)
	);

	// Name buffer: written in order while walking, replayed while emitting.
	dnsd_ram #(
		.WIDTH (8),
		.DEPTH (MAX_NAME_BYTES)
	) u_name_ram (
		.clk     (clk),
		.wr_en   (n_we),
		.wr_addr (len_q[NW-1:0]),
		.wr_data (n_wdata),
		.rd_addr (rp_d[NW-1:0]),
		.rd_data (n_rd)
	);

	// Handshake outputs.
	assign item_ready   = (state_q == S_IDLE);
	assign cfg_ready    = 1'b1;
	assign result_valid = out_valid_q;
	assign result       = out_q;
	assign out_free     = !out_valid_q || result_ready;

	// Shared helpers of the walk and the replay.
	assign wrap_done = PKT_POW2 || ({1'b0, red_q} < PKT_LIM);
	assign p_inc     = (p_q == PKT_TOP) ? '0 : p_q + 1'b1;
	assign hops_inc  = hops_q + 1'b1;
	assign rp_inc    = rp_q + 1'b1;
	assign cpos_inc  = cpos_q + 1'b1;
	assign is_last   = (rp_inc == len_q);
	assign chunk_full = (cpos_inc == CHUNK_N) || is_last;

	// Current chunk with the name byte from the buffer placed at its slot.
	always_comb begin
		chunk_new = chunk_q;
		for (int j = 0; j < CHUNK_BYTES; j++) begin
			if (cpos_q == CPW'(j)) begin
				chunk_new[8*j +: 8] = n_rd;
			end
		end
	end

	// Sequencer registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
			max_hops_q  <= HOPS_RESET;
		end else begin
			state_q     <= state_d;
			out_valid_q <= out_valid_d;
			if (cfg_valid && cfg_ready) begin
				max_hops_q <= cfg_data;
			end
		end
	end

	// Walk and replay registers.
	always_ff @(posedge clk) begin
		kind_q   <= kind_d;
		bval_q   <= bval_d;
		red_q    <= red_d;
		p_q      <= p_d;
		cnt_q    <= cnt_d;
		hops_q   <= hops_d;
		len_q    <= len_d;
		cons_q   <= cons_d;
		comp_q   <= comp_d;
		labels_q <= labels_d;
		hi_q     <= hi_d;
		fault_q  <= fault_d;
		rp_q     <= rp_d;
		cpos_q   <= cpos_d;
		chunk_q  <= chunk_d;
		out_q    <= out_d;
	end

	// Next state and datapath control.
	always_comb begin
		state_d     = state_q;
		kind_d      = kind_q;
		bval_d      = bval_q;
		red_d       = red_q;
		p_d         = p_q;
		cnt_d       = cnt_q;
		hops_d      = hops_q;
		len_d       = len_q;
		cons_d      = cons_q;
		comp_d      = comp_q;
		labels_d    = labels_q;
		hi_d        = hi_q;
		fault_d     = fault_q;
		rp_d        = rp_q;
		cpos_d      = cpos_q;
		chunk_d     = chunk_q;
		out_d       = out_q;
		out_valid_d = out_valid_q && !result_ready;
		pk_we       = 1'b0;
		n_we        = 1'b0;
		n_wdata     = DOT_CHAR;

		unique case (state_q)
			S_IDLE: begin
				if (item_valid) begin
					kind_d   = item.kind;
					bval_d   = item.byte_value;
					red_d    = RED_W'(item.position);
					hops_d   = '0;
					len_d    = '0;
					cons_d   = '0;
					comp_d   = 1'b0;
					labels_d = 1'b0;
					fault_d  = FAULT_NONE;
					state_d  = S_WRAP;
				end
			end

			// Reduce an offset modulo the buffer size, then store or start a walk.
			S_WRAP: begin
				if (wrap_done) begin
					if (kind_q == KIND_LOAD) begin
						pk_we   = 1'b1;
						state_d = S_IDLE;
					end else begin
						p_d     = red_q[ADDR_W-1:0];
						state_d = S_HDR;
					end
				end else begin
					red_d = red_q - PKT_LIM[RED_W-1:0];
				end
			end

			// A header byte: pointer, terminator or label length.
			S_HDR: begin
				if (pk_rd >= PTR_MIN) begin
					hi_d   = pk_rd[5:0];
					hops_d = hops_inc;
					if (!comp_q) begin
						cons_d = cons_q + CW'(2);
						comp_d = 1'b1;
					end
					if (hops_inc > {1'b0, max_hops_q}) begin
						fault_d = FAULT_HOPS;
						state_d = S_FINAL;
					end else begin
						p_d     = p_inc;
						state_d = S_PTR_LO;
					end
				end else if (pk_rd == 8'd0) begin
					if (!comp_q) begin
						cons_d = cons_q + CW'(1);
					end
					if (len_q == '0) begin
						state_d = S_FINAL;
					end else begin
						rp_d    = '0;
						cpos_d  = '0;
						chunk_d = '0;
						state_d = S_GATHER;
					end
				end else if (labels_q && (len_q >= NAME_MAX)) begin
					fault_d = FAULT_LONG;
					state_d = S_FINAL;
				end else begin
					// Dot between labels, then the label characters.
					if (labels_q) begin
						n_we  = 1'b1;
						len_d = len_q + 1'b1;
					end
					labels_d = 1'b1;
					cnt_d    = pk_rd;
					p_d      = p_inc;
					if (!comp_q) begin
						cons_d = cons_q + CW'(pk_rd) + CW'(1);
					end
					state_d = S_CH;
				end
			end

			// Low pointer byte completes the new offset.
			S_PTR_LO: begin
				red_d   = {hi_q, pk_rd};
				state_d = S_WRAP;
			end

			// One label character per cycle into the name buffer.
			S_CH: begin
				if (len_q >= NAME_MAX) begin
					fault_d = FAULT_LONG;
					state_d = S_FINAL;
				end else begin
					n_we    = 1'b1;
					n_wdata = pk_rd;
					len_d   = len_q + 1'b1;
					p_d     = p_inc;
					cnt_d   = cnt_q - 1'b1;
					if (cnt_q == 8'd1) begin
						state_d = S_HDR;
					end
				end
			end

			// Replay the name buffer into result words.
			S_GATHER: begin
				if (!chunk_full) begin
					chunk_d = chunk_new;
					cpos_d  = cpos_inc;
					rp_d    = rp_inc;
				end else if (out_free) begin
					out_d.name_chars      = chunk_new;
					out_d.char_count      = COUNT_W'(cpos_inc);
					out_d.last            = is_last;
					out_d.consumed_length = is_last ? CONSUMED_W'(cons_q) : '0;
					out_d.fault           = FAULT_NONE;
					out_valid_d           = 1'b1;
					chunk_d               = '0;
					cpos_d                = '0;
					rp_d                  = rp_inc;
					if (is_last) begin
						state_d = S_IDLE;
					end
				end
			end

			// Single result word for a root name or a fault.
			S_FINAL: begin
				if (out_free) begin
					out_d.name_chars      = '0;
					out_d.char_count      = '0;
					out_d.last            = 1'b1;
					out_d.consumed_length = (fault_q == FAULT_NONE) ? CONSUMED_W'(cons_q) : '0;
					out_d.fault           = fault_q;
					out_valid_d           = 1'b1;
					state_d               = S_IDLE;
				end
			end

			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule
